FILE: hdl/bdpc_pkg.sv
// Package: register indexes, event codes and reset defaults of the button classifier.
`default_nettype none

package bdpc_pkg;

    localparam int unsigned TimeWidth = 32;
    localparam int unsigned CfgWidth  = 16;
    localparam int unsigned IdxWidth  = 2;
    localparam int unsigned EvWidth   = 2;

    // Configuration register indexes
    localparam logic [IdxWidth-1:0] REG_ACTIVE_LOW    = 2'd0;
    localparam logic [IdxWidth-1:0] REG_DEBOUNCE_MS   = 2'd1;
    localparam logic [IdxWidth-1:0] REG_LONG_PRESS_MS = 2'd2;
    localparam logic [IdxWidth-1:0] REG_REPEAT_MS     = 2'd3;

    // Event codes
    localparam logic [EvWidth-1:0] EV_NONE   = 2'd0;
    localparam logic [EvWidth-1:0] EV_SHORT  = 2'd1;
    localparam logic [EvWidth-1:0] EV_LONG   = 2'd2;
    localparam logic [EvWidth-1:0] EV_REPEAT = 2'd3;

    // Reset values of the configuration registers
    localparam logic                RST_ACTIVE_LOW    = 1'b1;
    localparam logic [CfgWidth-1:0] RST_DEBOUNCE_MS   = 16'd50;
    localparam logic [CfgWidth-1:0] RST_LONG_PRESS_MS = 16'd3000;
    localparam logic [CfgWidth-1:0] RST_REPEAT_MS     = 16'd200;

    typedef logic [TimeWidth-1:0] time_ms_t;
    typedef logic [CfgWidth-1:0]  cfg_ms_t;
    typedef logic [EvWidth-1:0]   event_t;

endpackage

`default_nettype wire

FILE: hdl/button_debounce_press_classifier.sv
// Top level: debounced button classifier with short press, long press and auto-repeat.
// A request is registered at the input stage; its event is then loaded into the result
//   register together with the classifier state update, and offered from there.
// Throughput: one request per cycle unless out_ready is low while both stages are full.
// Reset (rst_n, asynchronous, active low): button released, all timestamps zero,
//   registers at active_low 1, debounce 50 ms, long press 3000 ms, repeat 200 ms.
`default_nettype none

module button_debounce_press_classifier
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_write,
    input  wire logic [bdpc_pkg::IdxWidth-1:0]     cfg_index,
    input  wire logic [bdpc_pkg::CfgWidth-1:0]     cfg_data,

    input  wire logic                              in_valid,
    output      logic                              in_ready,
    input  wire logic                              raw_level,
    input  wire logic [bdpc_pkg::TimeWidth-1:0]    now_ms,

    output      logic                              out_valid,
    input  wire logic                              out_ready,
    output      logic [bdpc_pkg::EvWidth-1:0]      event_code
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                  active_low_reg;
    bdpc_pkg::cfg_ms_t     debounce_ms_reg;
    bdpc_pkg::cfg_ms_t     long_press_ms_reg;
    bdpc_pkg::cfg_ms_t     repeat_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg    <= bdpc_pkg::RST_ACTIVE_LOW;
            debounce_ms_reg   <= bdpc_pkg::RST_DEBOUNCE_MS;
            long_press_ms_reg <= bdpc_pkg::RST_LONG_PRESS_MS;
            repeat_ms_reg     <= bdpc_pkg::RST_REPEAT_MS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bdpc_pkg::REG_ACTIVE_LOW:    active_low_reg    <= cfg_data[0];
                bdpc_pkg::REG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg_data;
                bdpc_pkg::REG_LONG_PRESS_MS: long_press_ms_reg <= cfg_data;
                bdpc_pkg::REG_REPEAT_MS:     repeat_ms_reg     <= cfg_data;
                default:                     active_low_reg    <= active_low_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input stage feeds the result register whenever that
    // register is empty or being drained this cycle.
    // ------------------------------------------------------------------
    logic                  s1_valid_reg;
    logic                  s1_raw_reg;
    bdpc_pkg::time_ms_t    s1_now_reg;
    logic                  out_valid_reg;
    bdpc_pkg::event_t      event_code_reg;

    logic                  advance;
    logic                  res_load;
    logic                  in_take;

    assign advance  = !out_valid_reg || out_ready;
    assign res_load = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Payload of the input stage; hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_raw_reg <= raw_level;
            s1_now_reg <= now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Classifier state
    // ------------------------------------------------------------------
    logic                  last_reading_reg,     last_reading_next;
    logic                  accepted_pressed_reg, accepted_pressed_next;
    logic                  long_fired_reg,       long_fired_next;
    bdpc_pkg::time_ms_t    last_change_time_reg, last_change_time_next;
    bdpc_pkg::time_ms_t    press_start_time_reg, press_start_time_next;
    bdpc_pkg::time_ms_t    last_repeat_time_reg, last_repeat_time_next;
    bdpc_pkg::event_t      event_next;

    logic                  reading;
    logic                  changed;
    logic                  stable;
    bdpc_pkg::time_ms_t    stable_dt;
    bdpc_pkg::time_ms_t    hold_dt;
    bdpc_pkg::time_ms_t    repeat_dt;
    logic                  hold_short;
    logic                  repeat_due;

    // Polarity correction: reading is 1 while the button is pressed
    assign reading   = s1_raw_reg ^ active_low_reg;
    assign changed   = reading != last_reading_reg;

    // A fresh change restarts the debounce window, so its elapsed time is zero
    assign stable_dt = changed ? '0 : (s1_now_reg - last_change_time_reg);
    assign stable    = stable_dt >= {{(bdpc_pkg::TimeWidth-bdpc_pkg::CfgWidth){1'b0}},
                                     debounce_ms_reg};

    // Wrapped elapsed times since press start and since last repeat
    assign hold_dt    = s1_now_reg - press_start_time_reg;
    assign repeat_dt  = s1_now_reg - last_repeat_time_reg;
    assign hold_short = hold_dt < {{(bdpc_pkg::TimeWidth-bdpc_pkg::CfgWidth){1'b0}},
                                   long_press_ms_reg};
    assign repeat_due = repeat_dt >= {{(bdpc_pkg::TimeWidth-bdpc_pkg::CfgWidth){1'b0}},
                                      repeat_ms_reg};

    always_comb
    begin
        last_reading_next     = reading;
        last_change_time_next = changed ? s1_now_reg : last_change_time_reg;
        accepted_pressed_next = accepted_pressed_reg;
        long_fired_next       = long_fired_reg;
        press_start_time_next = press_start_time_reg;
        last_repeat_time_next = last_repeat_time_reg;
        event_next            = bdpc_pkg::EV_NONE;

        if (stable)
        begin
            accepted_pressed_next = reading;
            priority if (reading && !accepted_pressed_reg)
            begin
                // Accepted press: record start, no event yet
                press_start_time_next = s1_now_reg;
                last_repeat_time_next = s1_now_reg;
                long_fired_next       = 1'b0;
            end
            else if (!reading && accepted_pressed_reg)
            begin
                // Accepted release: short press only if no long press was reported
                if (!long_fired_reg && hold_short)
                begin
                    event_next = bdpc_pkg::EV_SHORT;
                end
            end
            else if (reading)
            begin
                // Held: first the long press, then periodic repeats
                priority if (!long_fired_reg && !hold_short)
                begin
                    long_fired_next       = 1'b1;
                    last_repeat_time_next = s1_now_reg;
                    event_next            = bdpc_pkg::EV_LONG;
                end
                else if (long_fired_reg && repeat_due)
                begin
                    last_repeat_time_next = s1_now_reg;
                    event_next            = bdpc_pkg::EV_REPEAT;
                end
                else
                begin
                    event_next = bdpc_pkg::EV_NONE;
                end
            end
            else
            begin
                event_next = bdpc_pkg::EV_NONE;
            end
        end
    end

    // Advance state together with the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reading_reg     <= 1'b0;
            accepted_pressed_reg <= 1'b0;
            long_fired_reg       <= 1'b0;
            last_change_time_reg <= '0;
            press_start_time_reg <= '0;
            last_repeat_time_reg <= '0;
        end
        else if (res_load)
        begin
            last_reading_reg     <= last_reading_next;
            accepted_pressed_reg <= accepted_pressed_next;
            long_fired_reg       <= long_fired_next;
            last_change_time_reg <= last_change_time_next;
            press_start_time_reg <= press_start_time_next;
            last_repeat_time_reg <= last_repeat_time_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            event_code_reg <= event_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = event_code_reg;

`ifndef NO_ASSERTIONS
    a_long_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_load && event_next == bdpc_pkg::EV_LONG |=> long_fired_reg)
        else $error("long press reported without setting the long flag");

    a_short_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        res_load && event_next == bdpc_pkg::EV_SHORT |=> !accepted_pressed_reg)
        else $error("short press reported while still pressed");

    a_repeat_restamps: assert property (@(posedge clk) disable iff (!rst_n)
        res_load && event_next == bdpc_pkg::EV_REPEAT
        |=> last_repeat_time_reg == $past(s1_now_reg))
        else $error("repeat did not restamp the repeat time");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire
